@@ sv/rsp_pkg.sv @@
// Shared constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
`default_nettype none

package rsp_pkg;

    localparam int RSP_DATA_W       = 8;
    localparam int RSP_CFG_W        = 6;
    localparam int RSP_MAX_PARITY   = 32;
    localparam int RSP_PARITY_RESET = 10;

    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [7:0] RSP_FIELD_LOW = 8'h1D;

    // Multiply by alpha (x) in GF(256)
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = a[7] ? ({a[6:0], 1'b0} ^ RSP_FIELD_LOW) : {a[6:0], 1'b0};
    endfunction

    // Shift-and-add multiply in GF(256)
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

endpackage

`default_nettype wire

@@ sv/rsp_gen_build.sv @@
// Generator polynomial builder: multiplies in one (x + alpha^i) factor per cycle.
`default_nettype none

module rsp_gen_build #(
    parameter int MAX_PARITY = rsp_pkg::RSP_MAX_PARITY,
    parameter int CNT_W      = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rsp_pkg::RSP_CFG_W-1:0] cfg_wr_data,
    output logic                               busy,
    output logic [CNT_W-1:0]                   parity_cnt,
    output logic [7:0]                         coeffs [MAX_PARITY]
);
    import rsp_pkg::*;

    localparam int RESET_P = (RSP_PARITY_RESET > MAX_PARITY) ? MAX_PARITY : RSP_PARITY_RESET;

    logic [7:0]       g_reg    [MAX_PARITY+1];
    logic [7:0]       g_next   [MAX_PARITY+1];
    logic [7:0]       root_reg;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] p_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] p_clamped;

    // Map 0 to 1 and saturate at MAX_PARITY
    always_comb begin
        if (cfg_wr_data == '0) begin
            p_clamped = CNT_W'(1);
        end else if (int'(cfg_wr_data) > MAX_PARITY) begin
            p_clamped = CNT_W'(MAX_PARITY);
        end else begin
            p_clamped = CNT_W'(cfg_wr_data);
        end
    end

    // Lanes above the current degree stay zero, so update all of them at once
    always_comb begin
        for (int j = 0; j <= MAX_PARITY; j++) begin
            if (j == 0) begin
                g_next[j] = gf_mul(g_reg[j], root_reg);
            end else begin
                g_next[j] = g_reg[j-1] ^ gf_mul(g_reg[j], root_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            p_reg    <= aresetn ? p_clamped : CNT_W'(RESET_P);
            busy_reg <= 1'b1;
            step_reg <= '0;
            root_reg <= 8'h01;
            for (int j = 0; j <= MAX_PARITY; j++) begin
                g_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end else if (busy_reg) begin
            if (step_reg == p_reg) begin
                busy_reg <= 1'b0;
            end else begin
                g_reg    <= g_next;
                root_reg <= gf_xtime(root_reg);
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign busy       = busy_reg;
    assign parity_cnt = p_reg;

    always_comb begin
        for (int j = 0; j < MAX_PARITY; j++) begin
            coeffs[j] = g_reg[j];
        end
    end

endmodule

`default_nettype wire

@@ sv/rsp_lfsr.sv @@
// Input register and LFSR remainder update, one byte per cycle when not stalled.
`default_nettype none

module rsp_lfsr #(
    parameter int MAX_PARITY = rsp_pkg::RSP_MAX_PARITY,
    parameter int IDX_W      = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           clear,
    input  wire logic [7:0]                     coeffs [MAX_PARITY],
    input  wire logic [IDX_W-1:0]               top_idx,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rsp_pkg::RSP_DATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           can_load,
    output logic                                load,
    output logic [7:0]                          rem_out [MAX_PARITY]
);
    import rsp_pkg::*;

    logic                  in_valid_reg;
    logic [RSP_DATA_W-1:0] in_data_reg;
    logic                  in_last_reg;
    logic [7:0]            rem_reg  [MAX_PARITY];
    logic [7:0]            rem_next [MAX_PARITY];
    logic [7:0]            fb;
    logic                  advance;

    // A final byte waits until the parity buffer can take its remainder
    assign advance  = in_valid_reg && (!in_last_reg || can_load);
    assign s_tready = !clear && (!in_valid_reg || advance);
    assign load     = advance && in_last_reg;

    always_comb begin
        fb = in_data_reg ^ rem_reg[top_idx];
        for (int j = 0; j < MAX_PARITY; j++) begin
            if (j == 0) begin
                rem_next[j] = gf_mul(fb, coeffs[j]);
            end else begin
                rem_next[j] = rem_reg[j-1] ^ gf_mul(fb, coeffs[j]);
            end
        end
    end

    assign rem_out = rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                rem_reg[j] <= 8'h00;
            end
        end else if (advance) begin
            if (in_last_reg) begin
                // Remainder moves to the parity buffer; start the next message empty
                for (int j = 0; j < MAX_PARITY; j++) begin
                    rem_reg[j] <= 8'h00;
                end
            end else begin
                rem_reg <= rem_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/rsp_out_buf.sv @@
// Parity buffer: holds one block's remainder and sends it highest order first.
`default_nettype none

module rsp_out_buf #(
    parameter int MAX_PARITY = rsp_pkg::RSP_MAX_PARITY,
    parameter int IDX_W      = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic [7:0]                     rem_in [MAX_PARITY],
    input  wire logic [IDX_W-1:0]               top_idx,
    output logic                                can_load,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rsp_pkg::RSP_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import rsp_pkg::*;

    logic [7:0]       pbuf_reg [MAX_PARITY];
    logic [IDX_W-1:0] rd_idx_reg;
    logic             busy_reg;
    logic             final_taken;

    assign final_taken = busy_reg && m_tready && (rd_idx_reg == '0);
    assign can_load    = !busy_reg || final_taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (final_taken) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pbuf_reg   <= rem_in;
            rd_idx_reg <= top_idx;
        end else if (busy_reg && m_tready && rd_idx_reg != '0) begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = pbuf_reg[rd_idx_reg];
    assign m_tlast  = (rd_idx_reg == '0);

endmodule

`default_nettype wire

@@ sv/reed_solomon_parity_encoder.sv @@
// Top level of the GF(256) Reed-Solomon parity encoder.
//
//  channel | ports            | moves
//  --------+------------------+---------------------------------------------
//  input   | s_tvalid/tready  | tdata[7:0] data_byte, tlast last_data
//  output  | m_tvalid/tready  | tdata[7:0] parity_byte, tlast last_parity
//  config  | cfg_wr_en        | cfg_wr_data[5:0] parity_count
//
// One data byte is taken per cycle; the remainder update sits between the
// input register and the remainder register. The final byte of a message
// hands the remainder to the parity buffer, which sends p bytes, one per cycle while m_tready is high.
// A final byte stalls only while the previous block's parity is still draining.
// After reset and after each config write the generator is rebuilt, one
// root factor per cycle, and s_tready stays low meanwhile.
`default_nettype none

module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = rsp_pkg::RSP_MAX_PARITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rsp_pkg::RSP_CFG_W-1:0]  cfg_wr_data,  // [5:0] parity_count
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rsp_pkg::RSP_DATA_W-1:0] s_tdata,      // [7:0] data_byte
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rsp_pkg::RSP_DATA_W-1:0]      m_tdata,      // [7:0] parity_byte
    output logic                                m_tlast
);
    import rsp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    logic             gen_busy;
    logic [CNT_W-1:0] parity_cnt;
    logic [CNT_W-1:0] parity_cnt_m1;
    logic [IDX_W-1:0] top_idx;
    logic [7:0]       coeffs [MAX_PARITY];
    logic [7:0]       rem    [MAX_PARITY];
    logic             load;
    logic             can_load;

    assign parity_cnt_m1 = parity_cnt - 1'b1;
    assign top_idx       = parity_cnt_m1[IDX_W-1:0];

    rsp_gen_build #(
        .MAX_PARITY (MAX_PARITY),
        .CNT_W      (CNT_W)
    ) u_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .busy        (gen_busy),
        .parity_cnt  (parity_cnt),
        .coeffs      (coeffs)
    );

    rsp_lfsr #(
        .MAX_PARITY (MAX_PARITY),
        .IDX_W      (IDX_W)
    ) u_lfsr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (gen_busy),
        .coeffs   (coeffs),
        .top_idx  (top_idx),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .can_load (can_load),
        .load     (load),
        .rem_out  (rem)
    );

    rsp_out_buf #(
        .MAX_PARITY (MAX_PARITY),
        .IDX_W      (IDX_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .rem_in   (rem),
        .top_idx  (top_idx),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
